>>> hdl/wetd_pkg.sv
// ----------------------------------------------------------------------------
// wetd_pkg
// shared item types and sequencer states of the word embedding dictionary
// ----------------------------------------------------------------------------
package wetd_pkg;

	localparam int BYTE_W = 8;
	localparam int EMB_W  = 32;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] word_byte;
		logic              last;
		logic [EMB_W-1:0]  embedding_in;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [EMB_W-1:0] embedding_out;
		logic             added;
		logic             overflow;
	} rsp_t;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_SREQ  = 7'b0000100,
		ST_SCHK  = 7'b0001000,
		ST_NCHK  = 7'b0010000,
		ST_FREQ  = 7'b0100000,
		ST_FCHK  = 7'b1000000
	} state_t;

endpackage

>>> hdl/wetd_ram.sv
// ----------------------------------------------------------------------------
// wetd_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module wetd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/word_embedding_trie_dictionary.sv
// ----------------------------------------------------------------------------
// word_embedding_trie_dictionary
// maps words, spelled one byte per item, to 32-bit embeddings via a hashed trie
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its slot table, one slot per cycle,
// holding busy high. An item is taken when start is high and busy is low. The
// first byte of a word picks its root directly. Every later byte walks the
// slot table with linear probing: the item is accepted, then for each slot
// visited the slot is read and then checked, and an occupied slot also has its
// node read and compared. A final byte then reads the end node and, on an
// insert, writes it back marked terminal. The result of a final byte is shown
// on result for exactly one cycle with valid high; the receiver cannot stall
// it. Both tables sit in rams with a single registered read port.
// ----------------------------------------------------------------------------
module word_embedding_trie_dictionary
	import wetd_pkg::*;
#(
	parameter int HASH_SLOTS = 65536,
	parameter int MAX_CODES  = 32768
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic valid,
	output rsp_t result
);

	localparam int SW = $clog2(HASH_SLOTS);       // slot index width
	localparam int CW = $clog2(MAX_CODES);        // node code width
	localparam int KW = CW + BYTE_W;              // hash key width
	localparam int NW = CW + BYTE_W + 1 + EMB_W;  // node entry: parent, byte, term, emb
	localparam int TW = CW + 1;                   // slot entry: occupied flag, code

	// sequencer state and the word being walked
	state_t       state_q;
	req_t         req_q;
	logic [CW-1:0] cur_q;
	logic [CW-1:0] cand_q;
	logic [CW:0]   next_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] clr_q;
	logic          at_root_q;
	logic          missed_q;
	logic          created_q;
	logic          ovf_q;
	logic          valid_q;
	rsp_t          result_q;
	rsp_t          result_d;

	// memory ports
	logic          slot_we;
	logic [SW-1:0] slot_waddr;
	logic [TW-1:0] slot_wdata;
	logic [TW-1:0] slot_rdata;
	logic          node_we;
	logic [CW-1:0] node_waddr;
	logic [NW-1:0] node_wdata;
	logic [CW-1:0] node_raddr;
	logic [NW-1:0] node_rdata;

	// fields of the node read back
	logic [CW-1:0]     nd_parent;
	logic [BYTE_W-1:0] nd_byte;
	logic              nd_term;
	logic [EMB_W-1:0]  nd_emb;

	logic          slot_occ;
	logic [CW-1:0] slot_code;
	logic          can_create;
	logic          node_match;
	logic          final_ok;
	logic [SW-1:0] idx_inc;
	logic [SW-1:0] home_idx;
	logic          accept;

	// home slot of (parent, byte): fold the key, then bring it below the slot count
	function automatic logic [SW-1:0] slot_hash(input logic [CW-1:0] parent,
			input logic [BYTE_W-1:0] b);
		logic [KW-1:0] key;
		logic [SW-1:0] fold;
		logic [SW:0]   wide;
		key  = {parent, b};
		fold = SW'(key) ^ SW'(key >> SW) ^ SW'({b, 3'b101} * 5);
		wide = {1'b0, fold};
		if (wide >= (SW+1)'(HASH_SLOTS)) begin
			wide = wide - (SW+1)'(HASH_SLOTS);
		end
		return wide[SW-1:0];
	endfunction

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign valid      = valid_q;
	assign result     = result_q;

	assign slot_occ   = slot_rdata[TW-1];
	assign slot_code  = slot_rdata[CW-1:0];
	assign {nd_parent, nd_byte, nd_term, nd_emb} = node_rdata;
	assign can_create = (next_q < (CW+1)'(MAX_CODES));
	assign node_match = (nd_parent == cur_q) && (nd_byte == req_q.word_byte);
	assign final_ok   = !missed_q && !ovf_q && !at_root_q;
	assign idx_inc    = ({1'b0, idx_q} == (SW+1)'(HASH_SLOTS - 1)) ? '0 : idx_q + 1'b1;
	assign home_idx   = slot_hash(cur_q, request.word_byte);

	// memory port steering
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = {1'b1, next_q[CW-1:0]};
		node_we    = 1'b0;
		node_waddr = next_q[CW-1:0];
		node_wdata = {cur_q, req_q.word_byte, 1'b0, {EMB_W{1'b0}}};
		node_raddr = cur_q;
		unique case (state_q)
			ST_CLEAR: begin
				// empty every slot; roots come back as plain nodes
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
				node_we    = (clr_q < SW'(256));
				node_waddr = CW'(clr_q);
				node_wdata = {{CW{1'b0}}, clr_q[BYTE_W-1:0], 1'b0, {EMB_W{1'b0}}};
			end
			ST_SCHK: begin
				node_raddr = slot_code;
				// free slot on an insert: link a fresh node here
				if (!slot_occ && req_q.kind == KIND_INSERT && can_create) begin
					slot_we = 1'b1;
					node_we = 1'b1;
				end
			end
			ST_FCHK: begin
				// mark end node terminal, keeping its key
				if (req_q.kind == KIND_INSERT && final_ok) begin
					node_we    = 1'b1;
					node_waddr = cur_q;
					node_wdata = {nd_parent, nd_byte, 1'b1, req_q.embedding_in};
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			next_q    <= (CW+1)'(256);
			cur_q     <= '0;
			cand_q    <= '0;
			idx_q     <= '0;
			at_root_q <= 1'b1;
			missed_q  <= 1'b0;
			created_q <= 1'b0;
			ovf_q     <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if ({1'b0, clr_q} == (SW+1)'(HASH_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (!missed_q && !ovf_q && !at_root_q) begin
							idx_q   <= home_idx;
							state_q <= ST_SREQ;
						end else begin
							// first byte picks its root directly
							if (!missed_q && !ovf_q) begin
								cur_q     <= CW'(request.word_byte);
								at_root_q <= 1'b0;
							end
							state_q <= request.last ? ST_FREQ : ST_IDLE;
						end
					end
				end
				ST_SREQ: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					if (slot_occ) begin
						cand_q  <= slot_code;
						state_q <= ST_NCHK;
					end else begin
						if (req_q.kind == KIND_INSERT) begin
							if (can_create) begin
								cur_q     <= next_q[CW-1:0];
								next_q    <= next_q + 1'b1;
								created_q <= 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							missed_q <= 1'b1;
						end
						state_q <= req_q.last ? ST_FREQ : ST_IDLE;
					end
				end
				ST_NCHK: begin
					if (node_match) begin
						cur_q   <= cand_q;
						state_q <= req_q.last ? ST_FREQ : ST_IDLE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= ST_SREQ;
					end
				end
				ST_FREQ: begin
					state_q <= ST_FCHK;
				end
				ST_FCHK: begin
					valid_q   <= 1'b1;
					// word done: back to the roots
					cur_q     <= '0;
					at_root_q <= 1'b1;
					missed_q  <= 1'b0;
					created_q <= 1'b0;
					ovf_q     <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// result of a final byte, from the end node read back
	always_comb begin
		result_d = '0;
		if (req_q.kind == KIND_LOOKUP) begin
			result_d.hit           = final_ok && nd_term;
			result_d.embedding_out = (final_ok && nd_term) ? nd_emb : '1;
		end else if (ovf_q) begin
			result_d.overflow = 1'b1;
		end else if (final_ok) begin
			result_d.added = created_q || !nd_term;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (state_q == ST_FCHK) begin
			result_q <= result_d;
		end
	end

	wetd_ram #(
		.WIDTH (TW),
		.DEPTH (HASH_SLOTS),
		.AW    (SW)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (idx_q),
		.rdata (slot_rdata)
	);

	wetd_ram #(
		.WIDTH (NW),
		.DEPTH (MAX_CODES),
		.AW    (CW)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

endmodule

>>> tb/word_embedding_trie_dictionary_test.sv
// ----------------------------------------------------------------------------
// word_embedding_trie_dictionary_test
// drives words as byte items into the trie dictionary and checks every result
// against a behavioral dictionary kept in the testbench; a directed set, then
// random words from a small pool, then a tail of pool words and extensions
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module word_embedding_trie_dictionary_test;
	import wetd_pkg::*;

	localparam int MAX_CODES = 32768;
	localparam int CODE_MASK = 'h7FFF;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic valid;
	rsp_t result;

	word_embedding_trie_dictionary dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.valid(valid),
		.result(result)
	);

	// items waiting to be sent, with a flag that holds the item until drained
	req_t byte_items[$];
	bit   drain_first[$];
	rsp_t word_answers[$];
	int   mismatches;
	int   accepted_count;
	int   quiet_cycles;

	// behavioral dictionary: child code keyed by parent*256+byte
	int       child_code[int];
	bit       term_flag[MAX_CODES];
	bit [31:0] term_emb[MAX_CODES];
	int       free_code;
	int       walk_node;
	bit       walk_at_root;
	bit       walk_missed;
	bit       walk_created;
	bit       walk_overflowed;

	// small pool of words so lookups hit and inserts repeat
	byte unsigned word_pool[40][$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("word_embedding_trie_dictionary regression: fail");
		$finish;
	end

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// advance the dictionary by one item; pushes the answer of a final byte
	task automatic dictionary_step(input req_t it);
		int key;
		int cur;
		rsp_t ans;
		if (!walk_missed && !walk_overflowed) begin
			if (walk_at_root) begin
				walk_node = it.word_byte;
				walk_at_root = 0;
			end else begin
				key = walk_node * 256 + it.word_byte;
				if (child_code.exists(key)) begin
					walk_node = child_code[key];
				end else if (it.kind == KIND_INSERT) begin
					if (free_code < MAX_CODES) begin
						child_code[key] = free_code;
						term_flag[free_code] = 0;
						term_emb[free_code] = '0;
						walk_node = free_code;
						free_code++;
						walk_created = 1;
					end else begin
						walk_overflowed = 1;
					end
				end else begin
					walk_missed = 1;
				end
			end
		end
		if (!it.last) return;
		ans = '0;
		cur = walk_node & CODE_MASK;
		if (it.kind == KIND_LOOKUP) begin
			ans.embedding_out = '1;
			if (!walk_missed && !walk_overflowed && !walk_at_root && term_flag[cur]) begin
				ans.hit = 1;
				ans.embedding_out = term_emb[cur];
			end
		end else if (walk_overflowed) begin
			ans.overflow = 1;
		end else if (!walk_missed && !walk_at_root) begin
			ans.added = walk_created || !term_flag[cur];
			term_flag[cur] = 1;
			term_emb[cur] = it.embedding_in;
		end
		word_answers.push_back(ans);
		walk_node = 0;
		walk_at_root = 1;
		walk_missed = 0;
		walk_created = 0;
		walk_overflowed = 0;
	endtask

	task automatic add_item(input bit k, input byte unsigned b, input bit l,
			input bit [31:0] e, input bit hold);
		req_t it;
		it.kind = k;
		it.word_byte = b;
		it.last = l;
		it.embedding_in = e;
		byte_items.push_back(it);
		drain_first.push_back(hold);
	endtask

	// whole word with one kind, held off until the block drains if asked
	task automatic add_word(input bit k, input byte unsigned w[$], input bit [31:0] e,
			input bit hold);
		for (int i = 0; i < w.size(); i++)
			add_item(k, w[i], i == w.size() - 1, e, hold && i == 0);
	endtask

	// driver: present the head item, pop and predict it on acceptance
	always @(posedge clk or negedge arst_n) begin
		bit took;
		bit idle_roll;
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
			quiet_cycles <= 0;
		end else begin
			took = start && !busy;
			if (took) begin
				dictionary_step(request);
				void'(byte_items.pop_front());
				void'(drain_first.pop_front());
				accepted_count++;
			end
			if (word_answers.size() == 0 && !busy && !start && !valid)
				quiet_cycles <= quiet_cycles + 1;
			else
				quiet_cycles <= 0;
			if (!start || took) begin
				// long idle-free stretch in the middle of the random part
				idle_roll = !(accepted_count > 150 && accepted_count < 350) &&
					$urandom_range(99) < 37;
				if (byte_items.size() == 0 || idle_roll)
					start <= 1'b0;
				else if (drain_first[0] && quiet_cycles < 12)
					start <= 1'b0;
				else begin
					start <= 1'b1;
					request <= byte_items[0];
				end
			end
		end
	end

	// monitor: every strobe must match the oldest pending answer
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && valid) begin
			if (word_answers.size() == 0) begin
				report("result with nothing pending");
			end else begin
				want = word_answers.pop_front();
				if (result.hit !== want.hit)
					report($sformatf("hit %b want %b", result.hit, want.hit));
				if (result.embedding_out !== want.embedding_out)
					report($sformatf("embedding_out %h want %h",
						result.embedding_out, want.embedding_out));
				if (result.added !== want.added)
					report($sformatf("added %b want %b", result.added, want.added));
				if (result.overflow !== want.overflow)
					report($sformatf("overflow %b want %b", result.overflow, want.overflow));
			end
		end
	end

	initial begin
		byte unsigned w[$];
		int n;
		int p;
		bit k;
		mismatches = 0;
		accepted_count = 0;
		free_code = 256;
		walk_node = 0;
		walk_at_root = 1;
		walk_missed = 0;
		walk_created = 0;
		walk_overflowed = 0;
		start = 1'b0;
		request = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: root words at both byte extremes
		add_item(KIND_INSERT, 8'h00, 1, 32'h0000_0000, 0);
		add_item(KIND_INSERT, 8'hFF, 1, 32'hFFFF_FFFF, 0);
		add_item(KIND_LOOKUP, 8'h00, 1, 32'h0, 0);
		add_item(KIND_LOOKUP, 8'hFF, 1, 32'h0, 0);
		add_item(KIND_LOOKUP, 8'h41, 1, 32'h0, 0);
		// two-byte word, then its re-insert with a new embedding
		w = '{8'h61, 8'h62};
		add_word(KIND_INSERT, w, 32'hA5A5_5A5A, 0);
		add_word(KIND_LOOKUP, w, 32'h0, 0);
		add_word(KIND_INSERT, w, 32'h5A5A_A5A5, 0);
		add_word(KIND_LOOKUP, w, 32'h0, 0);
		// prefix of a longer word is not terminal
		w = '{8'h61, 8'h62, 8'h63};
		add_word(KIND_INSERT, w, 32'h1234_5678, 0);
		add_item(KIND_LOOKUP, 8'h61, 1, 32'h0, 0);
		// lookup that misses midway, later bytes ignored
		w = '{8'h61, 8'h7A, 8'h63};
		add_word(KIND_LOOKUP, w, 32'h0, 0);
		// mixed kinds: lookup misses then insert ends the word
		add_item(KIND_LOOKUP, 8'h10, 0, 32'h0, 0);
		add_item(KIND_LOOKUP, 8'h11, 0, 32'h0, 0);
		add_item(KIND_INSERT, 8'h12, 1, 32'hDEAD_BEEF, 0);
		// mixed kinds: insert creates, lookup ends
		add_item(KIND_INSERT, 8'h20, 0, 32'h0, 0);
		add_item(KIND_INSERT, 8'h21, 0, 32'h0, 0);
		add_item(KIND_LOOKUP, 8'h22, 1, 32'h0, 0);

		// pool of short words
		for (int i = 0; i < 40; i++) begin
			n = $urandom_range(1, 6);
			for (int j = 0; j < n; j++)
				word_pool[i].push_back($urandom_range(7) == 0 ?
					8'($urandom) : 8'($urandom_range(8'h60, 8'h67)));
		end

		// random part: mostly pool words, some noise and mixed words
		while (byte_items.size() + accepted_count < 380) begin
			p = $urandom_range(99);
			k = $urandom_range(1);
			if (p < 75) begin
				add_word(k, word_pool[$urandom_range(39)], $urandom,
					accepted_count == 0 && byte_items.size() > 320 &&
					byte_items.size() < 330);
			end else if (p < 88) begin
				w = word_pool[$urandom_range(39)];
				for (int j = 0; j < w.size(); j++)
					add_item($urandom_range(1), w[j], j == w.size() - 1, $urandom, 0);
			end else begin
				add_item(k, 8'($urandom), $urandom_range(3) == 0, $urandom, 0);
			end
		end
		// sender waits for the block to drain at least once
		add_word(KIND_LOOKUP, word_pool[0], 32'h0, 1);
		wait (byte_items.size() == 0);

		// tail: pool words and one-byte extensions of them
		for (int i = 0; i < 60; i++) begin
			w = word_pool[$urandom_range(39)];
			w.push_back(8'($urandom));
			add_word($urandom_range(1), ($urandom_range(1) ? word_pool[i % 40] : w),
				$urandom, 0);
		end
		wait (byte_items.size() == 0);
		wait (word_answers.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("word_embedding_trie_dictionary regression: pass");
		else
			$display("word_embedding_trie_dictionary regression: fail");
		$finish;
	end

endmodule
